// ===== hdl/tac_pkg.sv =====
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, codes and reset values of the temperature alarm controller.
// ----------------------------------------------------------------------------
package tac_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int MAX_DIGITS      = 3;

	localparam logic [7:0] TEMP_SCALE_RST = 8'd200;
	localparam logic [7:0] THRESHOLD_RST  = 8'd120;

	typedef enum logic [1:0] {
		MODE_MAIN  = 2'd0,
		MODE_ALARM = 2'd1,
		MODE_KEY   = 2'd2,
		MODE_TERM  = 2'd3
	} mode_t;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_KEY    = 2'd1;
	localparam logic [1:0] OP_TERM   = 2'd2;

	localparam logic [3:0] KEY_DIGIT_ONE  = 4'd1;
	localparam logic [3:0] KEY_DIGIT_ZERO = 4'd10;
	localparam logic [3:0] KEY_CANCEL     = 4'd12;
	localparam logic [3:0] KEY_TOGGLE     = 4'd13;
	localparam logic [3:0] KEY_ENTER      = 4'd15;

	localparam logic [7:0] CHR_SILENCE = 8'h53; // 'S'
	localparam logic [7:0] CHR_ENTER   = 8'h47; // 'G'
	localparam logic [7:0] CHR_CANCEL  = 8'h43; // 'C'
	localparam logic [7:0] CHR_CONFIRM = 8'h4F; // 'O'
	localparam logic [7:0] CHR_ZERO    = 8'h30; // '0'
	localparam logic [7:0] CHR_NINE    = 8'h39; // '9'

	typedef struct packed {
		mode_t      mode;
		logic [7:0] temp;
		logic [7:0] threshold;
		logic       enable;
		logic [7:0] entry;
		logic [1:0] digits;
	} tac_state_t;

endpackage

// ===== hdl/tac_step.sv =====
// ----------------------------------------------------------------------------
// tac_step
// Next-state logic for one event: sample conversion, keypad and terminal
// commands, digit entry and the alarm check that follows every event.
// ----------------------------------------------------------------------------
module tac_step import tac_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  tac_state_t             cur,
	input  logic [1:0]             operation,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [3:0]             key_code,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             temp_scale,
	output tac_state_t             nxt,
	output logic                   digit_accepted
);

	logic [SAMPLE_BITS+7:0] product;
	logic                   dig_req;
	logic [3:0]             dig_val;
	logic [11:0]            ent_sum;
	tac_state_t             upd;

	assign product = {8'd0, sample} * {{SAMPLE_BITS{1'b0}}, temp_scale};
	assign ent_sum = {4'd0, cur.entry} * 12'd10 + {8'd0, dig_val};

	always_comb begin
		upd            = cur;
		dig_req        = 1'b0;
		dig_val        = 4'd0;
		digit_accepted = 1'b0;

		unique case (operation)
			OP_SAMPLE: begin
				upd.temp = product[SAMPLE_BITS +: 8];
			end
			OP_KEY: begin
				if (key_code == KEY_TOGGLE && cur.mode == MODE_MAIN) begin
					upd.enable = ~cur.enable;
				end else if (key_code == KEY_CANCEL && cur.mode == MODE_ALARM) begin
					upd.enable = 1'b0;
					upd.mode   = MODE_MAIN;
				end else if (key_code == KEY_ENTER && cur.mode == MODE_MAIN) begin
					upd.mode   = MODE_KEY;
					upd.entry  = 8'd0;
					upd.digits = 2'd0;
				end else if (key_code == KEY_CANCEL && cur.mode == MODE_KEY) begin
					upd.mode = MODE_MAIN;
				end else if (key_code == KEY_ENTER && cur.mode == MODE_KEY) begin
					upd.threshold = cur.entry;
					upd.mode      = MODE_MAIN;
				end else if (key_code >= KEY_DIGIT_ONE && key_code <= KEY_DIGIT_ZERO
						&& cur.mode == MODE_KEY) begin
					dig_req = 1'b1;
					dig_val = (key_code == KEY_DIGIT_ZERO) ? 4'd0 : key_code;
				end
			end
			OP_TERM: begin
				if (rx_byte == CHR_SILENCE && cur.mode == MODE_ALARM) begin
					upd.enable = 1'b0;
					upd.mode   = MODE_MAIN;
				end else if (rx_byte == CHR_ENTER && cur.mode == MODE_MAIN) begin
					upd.mode   = MODE_TERM;
					upd.entry  = 8'd0;
					upd.digits = 2'd0;
				end else if (rx_byte == CHR_CANCEL && cur.mode == MODE_TERM) begin
					upd.mode = MODE_MAIN;
				end else if (rx_byte == CHR_CONFIRM && cur.mode == MODE_TERM) begin
					upd.threshold = cur.entry;
					upd.mode      = MODE_MAIN;
				end else if (rx_byte >= CHR_ZERO && rx_byte <= CHR_NINE
						&& cur.mode == MODE_TERM) begin
					dig_req = 1'b1;
					dig_val = 4'(rx_byte - CHR_ZERO);
				end
			end
			default: begin
			end
		endcase

		// digits past the limit are dropped silently
		if (dig_req && cur.digits < 2'(MAX_DIGITS)) begin
			upd.entry      = (ent_sum > 12'd255) ? 8'd255 : ent_sum[7:0];
			upd.digits     = cur.digits + 2'd1;
			digit_accepted = 1'b1;
		end

		nxt = upd;
		// alarm check runs after every event and overrides any mode
		if (upd.temp >= upd.threshold && upd.enable) begin
			nxt.mode = MODE_ALARM;
		end else if (upd.mode == MODE_ALARM && upd.temp < upd.threshold) begin
			nxt.mode = MODE_MAIN;
		end
	end

endmodule

// ===== hdl/temperature_alarm_controller.sv =====
// ----------------------------------------------------------------------------
// temperature_alarm_controller
// Alarm controller driven by converter samples, keypad keys and terminal bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: item_valid / item_stall with operation, sample, key_code
//   and rx_byte. One beat is one event; the field that operation does not
//   select is ignored.
//   Result channel: result_valid / result_stall, one result beat per item,
//   showing the full controller state after that event.
//   Config: cfg_wr_en writes cfg_wr_data into the temperature scale; write
//   it only while no item is in flight.
//   Path: a taken beat passes the input register, then the result register,
//   and a stalled result can hold it in the input register.
//   Throughput: one item per cycle while the result is not stalled; the event
//   logic between the input register and the result register decides one event per clock.
//   Stall: a stalled result holds; the input register keeps its item and
//   item_stall rises only when both registers are full.
//   Reset: main mode, temperature 0, threshold 120, alarm enabled, empty
//   entry, scale 200, both registers empty.
// ----------------------------------------------------------------------------
module temperature_alarm_controller import tac_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [1:0]             operation,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [3:0]             key_code,
	input  logic [7:0]             rx_byte,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [1:0]             mode_now,
	output logic [7:0]             temperature,
	output logic [7:0]             threshold,
	output logic                   alarm_enabled,
	output logic                   buzzer_on,
	output logic [7:0]             entry_value,
	output logic [1:0]             entry_digits,
	output logic                   digit_accepted
);

	logic                   valid_s1;
	logic [1:0]             operation_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [3:0]             key_code_s1;
	logic [7:0]             rx_byte_s1;

	logic [7:0]  temp_scale_q;
	tac_state_t  state_q;
	tac_state_t  state_nxt;
	logic        accepted_nxt;

	logic        result_valid_q;
	logic [1:0]  mode_q;
	logic [7:0]  temp_q;
	logic [7:0]  threshold_q;
	logic        enable_q;
	logic        buzzer_q;
	logic [7:0]  entry_q;
	logic [1:0]  digits_q;
	logic        accepted_q;

	logic advance;
	logic item_take;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_scale_q <= TEMP_SCALE_RST;
		end else if (cfg_wr_en) begin
			temp_scale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			operation_s1 <= operation;
			sample_s1    <= sample;
			key_code_s1  <= key_code;
			rx_byte_s1   <= rx_byte;
		end
	end

	tac_step #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_step (
		.cur           (state_q),
		.operation     (operation_s1),
		.sample        (sample_s1),
		.key_code      (key_code_s1),
		.rx_byte       (rx_byte_s1),
		.temp_scale    (temp_scale_q),
		.nxt           (state_nxt),
		.digit_accepted(accepted_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= MODE_MAIN;
			state_q.temp      <= 8'd0;
			state_q.threshold <= THRESHOLD_RST;
			state_q.enable    <= 1'b1;
			state_q.entry     <= 8'd0;
			state_q.digits    <= 2'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_q      <= state_nxt.mode;
			temp_q      <= state_nxt.temp;
			threshold_q <= state_nxt.threshold;
			enable_q    <= state_nxt.enable;
			buzzer_q    <= (state_nxt.mode == MODE_ALARM);
			entry_q     <= state_nxt.entry;
			digits_q    <= state_nxt.digits;
			accepted_q  <= accepted_nxt;
		end
	end

	assign result_valid   = result_valid_q;
	assign mode_now       = mode_q;
	assign temperature    = temp_q;
	assign threshold      = threshold_q;
	assign alarm_enabled  = enable_q;
	assign buzzer_on      = buzzer_q;
	assign entry_value    = entry_q;
	assign entry_digits   = digits_q;
	assign digit_accepted = accepted_q;

	// buzzer follows the alarming mode exactly
	a_buzzer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (buzzer_on == (mode_now == MODE_ALARM)))
		else $error("buzzer does not match alarming mode");

	// alarming can only be held while raising is enabled
	a_alarm_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && buzzer_on |-> alarm_enabled)
		else $error("alarming while alarm disabled");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && digit_accepted |-> entry_digits != 2'd0)
		else $error("digit accepted with empty digit count");

	// the engine state only moves when a beat goes through the event logic
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an event");

endmodule
